### rtl/core/kreg_pkg.sv
// Shared constants, codes and controller/datapath interface types for the keyed edge gate.
package kreg_pkg;

    // Table depth used when the top level is not told otherwise.
    localparam int SLOTS_DEF = 256;

    // Payload length thresholds in bytes.
    localparam logic [7:0] LEN_MIN_FIRE = 8'd32;
    localparam logic [7:0] LEN_MIN_ID   = 8'd36;
    localparam logic [7:0] LEN_MIN_MODE = 8'd38;

    // Stream field widths.
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    // Outcome codes reported with every result.
    localparam logic [1:0] OUT_SHORT      = 2'd0;
    localparam logic [1:0] OUT_COND_FALSE = 2'd1;
    localparam logic [1:0] OUT_SUPPRESSED = 2'd2;
    localparam logic [1:0] OUT_FIRED      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted event and arm the scan
        logic scan;      // table scan in progress
        logic res_load;  // move the finished result into the output register
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_track; // the event on the input needs a table access
        logic hit;        // matching slot found, level written back this cycle
        logic miss;       // scan ended without a match, slot claimed this cycle
        logic out_busy;   // output register holds a result that is not taken
    } t_sts;

endpackage

### rtl/core/keyed_rising_edge_gate_unit.sv
// Top level of the keyed edge gate: stream ports, controller and datapath.
//
// Usage: one event enters on the slave stream as a transaction on s_axis; its
// tdata packs payload_length, condition_word, event_id, once_byte and
// continuous_byte from the lowest bit up. Exactly one result leaves on the
// master stream per event: tdata carries pulse_id, tuser carries fire in bit 0
// and outcome in bits 2:1.
// Events that need no table access (short payload, identifier zero, once mode
// off, or continuous mode with a true condition) go from acceptance straight
// to the result load, which waits only while the output register is busy.
// Once-mode events with a nonzero identifier scan the slot table, one slot
// per clock through the single read port of the key and level memories, and
// stop at the first matching slot or end with a miss after the last slot.
// Each event's result is loaded before the next event is taken; a new event
// is taken in the cycle after the previous result is loaded.
// Reset clears all slot occupancy bits at once; no clearing pass is needed.
// The result sits in an output register, so the next event is accepted while
// a result waits; if the receiver stalls, the following result waits in the
// datapath and the slave side stays not ready until the register frees up.
module keyed_rising_edge_gate_unit
    import kreg_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // payload_length[7:0], condition_word[39:8], event_id[71:40],
    // once_byte[79:72], continuous_byte[87:80]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // pulse_id[31:0]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // fire[0], outcome[2:1]
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    t_ctl        ctl;
    t_sts        sts;
    logic        fire;
    logic [1:0]  outcome;

    kreg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    kreg_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_payload_length  (i_s_axis_tdata[7:0]),
        .i_condition_word  (i_s_axis_tdata[39:8]),
        .i_event_id        (i_s_axis_tdata[71:40]),
        .i_once_byte       (i_s_axis_tdata[79:72]),
        .i_continuous_byte (i_s_axis_tdata[87:80]),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_fire            (fire),
        .o_outcome         (outcome),
        .o_pulse_id        (o_m_axis_tdata)
    );

    assign o_m_axis_tuser = {outcome, fire};

endmodule

### rtl/core/kreg_ctrl.sv
// Controller state machine of the keyed edge gate.
module kreg_ctrl
    import kreg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        o_ctl          = '0;
        o_ctl.load     = accept;
        o_ctl.scan     = (r_state == ST_SCAN);
        o_ctl.res_load = (r_state == ST_DONE) && !i_sts.out_busy;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_sts.need_track ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_sts.hit || i_sts.miss) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A scan ends in the cycle after its hit or miss write.
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.scan && (i_sts.hit || i_sts.miss)) |=> !o_ctl.scan)
        else $error("scan continued after table write");

endmodule

### rtl/core/kreg_dpath.sv
// Datapath of the keyed edge gate: event decode, slot table, scan pipeline and result register.
module kreg_dpath
    import kreg_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [7:0]  i_payload_length,
    input  logic [31:0] i_condition_word,
    input  logic [31:0] i_event_id,
    input  logic [7:0]  i_once_byte,
    input  logic [7:0]  i_continuous_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_fire,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_pulse_id
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    // Slot table.
    logic [31:0]      mem_key [SLOTS];
    logic             mem_lvl [SLOTS];
    logic [SLOTS-1:0] r_used;

    // Decode of the event on the input.
    logic        in_short;
    logic        in_cond;
    logic [31:0] in_key;
    logic        in_once;
    logic        in_cont;

    // Captured event.
    logic        r_short;
    logic        r_cond;
    logic        r_cont;
    logic [31:0] r_key;
    logic        r_edge;

    // Scan pipeline.
    logic          r_issue;
    logic [AW-1:0] r_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [31:0]   r_rd_key;
    logic          r_rd_level;
    logic          r_rd_used;
    logic          r_have_free;
    logic [AW-1:0] r_free_idx;

    logic          rd_en;
    logic          hit;
    logic          miss;
    logic [AW-1:0] victim;
    logic [AW-1:0] w_idx;

    // Result.
    logic        r_out_vld;
    logic        r_fire;
    logic [1:0]  r_outcome;
    logic [31:0] r_pulse_id;
    logic        res_fire;
    logic [1:0]  res_outcome;

    always_comb begin
        in_short = (i_payload_length < LEN_MIN_FIRE);
        in_cond  = |i_condition_word;
        in_key   = (i_payload_length >= LEN_MIN_ID) ? i_event_id : 32'd0;
        in_once  = (i_payload_length >= LEN_MIN_MODE) && (|i_once_byte);
        in_cont  = ((i_payload_length >= LEN_MIN_MODE) && (|i_continuous_byte)) || !in_once;
    end

    assign rd_en  = i_ctl.scan && r_issue;
    assign hit    = i_ctl.scan && r_rd_vld && r_rd_used && (r_rd_key == r_key);
    assign miss   = i_ctl.scan && r_rd_vld && (r_rd_idx == LAST) && !hit;
    assign victim = r_have_free ? r_free_idx : (!r_rd_used ? r_rd_idx : '0);
    assign w_idx  = hit ? r_rd_idx : victim;

    always_comb begin
        o_sts            = '0;
        o_sts.need_track = !in_short && in_once && (in_key != 32'd0) && !(in_cond && in_cont);
        o_sts.hit        = hit;
        o_sts.miss       = miss;
        o_sts.out_busy   = r_out_vld && !i_ready;
    end

    // Table memories: read at the scan address, written at the end of a scan.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key   <= mem_key[r_addr];
            r_rd_level <= mem_lvl[r_addr];
            r_rd_idx   <= r_addr;
        end
        if (hit || miss) begin
            mem_lvl[w_idx] <= r_cond;
        end
        if (miss) begin
            mem_key[victim] <= r_key;
        end
    end

    // Scan control and slot occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_issue     <= 1'b0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_used   <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_ctl.load) begin
            r_issue     <= 1'b1;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_ctl.scan) begin
            r_rd_vld <= rd_en;
            if (rd_en) begin
                r_rd_used <= r_used[r_addr];
                if (r_addr == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (r_rd_vld && !r_rd_used && !r_have_free) begin
                r_have_free <= 1'b1;
            end
            if (miss) begin
                r_used[victim] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan && r_rd_vld && !r_rd_used && !r_have_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    // Captured event and edge result; identifier zero passes the level through.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_short <= in_short;
            r_cond  <= in_cond;
            r_cont  <= in_cont;
            r_key   <= in_key;
            r_edge  <= in_cond;
        end else if (hit) begin
            r_edge <= r_cond && !r_rd_level;
        end else if (miss) begin
            r_edge <= r_cond;
        end
    end

    always_comb begin
        res_fire = !r_short && r_cond && (r_cont || r_edge);
        if (r_short) begin
            res_outcome = OUT_SHORT;
        end else if (!r_cond) begin
            res_outcome = OUT_COND_FALSE;
        end else if (res_fire) begin
            res_outcome = OUT_FIRED;
        end else begin
            res_outcome = OUT_SUPPRESSED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_fire     <= res_fire;
            r_outcome  <= res_outcome;
            r_pulse_id <= (r_key == 32'd0) ? 32'd1 : r_key;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_fire     = r_fire;
    assign o_outcome  = r_outcome;
    assign o_pulse_id = r_pulse_id;

    a_fire_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.res_load && res_fire) |=> (r_outcome == OUT_FIRED))
        else $error("fire without fired outcome");

    a_short_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.res_load && r_short) |=> (r_pulse_id == 32'd1 && !r_fire))
        else $error("short payload result malformed");

    a_claim_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        miss |=> r_used[$past(victim)])
        else $error("claimed slot not marked used");

endmodule
